@@ src/accalu_pkg.sv @@
// Shared types and operation codes for the accumulator ALU.
package accalu_pkg;

    // Operation codes
    localparam logic [3:0] ACT_ADD  = 4'd0;
    localparam logic [3:0] ACT_ADC  = 4'd1;
    localparam logic [3:0] ACT_SUB  = 4'd2;
    localparam logic [3:0] ACT_SBC  = 4'd3;
    localparam logic [3:0] ACT_ADDD = 4'd4;
    localparam logic [3:0] ACT_SUBD = 4'd5;
    localparam logic [3:0] ACT_MUL  = 4'd6;
    localparam logic [3:0] ACT_SEX  = 4'd7;
    localparam logic [3:0] ACT_ASL  = 4'd8;
    localparam logic [3:0] ACT_ASR  = 4'd9;
    localparam logic [3:0] ACT_LSR  = 4'd10;
    localparam logic [3:0] ACT_ROL  = 4'd11;
    localparam logic [3:0] ACT_ROR  = 4'd12;
    localparam logic [3:0] ACT_DAA  = 4'd13;
    localparam logic [3:0] ACT_BRA  = 4'd14;

    // Target codes
    localparam logic [1:0] TGT_A = 2'd0;
    localparam logic [1:0] TGT_B = 2'd1;

    // Branch conditions
    localparam logic [3:0] CC_ALWAYS = 4'd0;
    localparam logic [3:0] CC_NEVER  = 4'd1;
    localparam logic [3:0] CC_HI     = 4'd2;
    localparam logic [3:0] CC_LS     = 4'd3;
    localparam logic [3:0] CC_CC     = 4'd4;
    localparam logic [3:0] CC_CS     = 4'd5;
    localparam logic [3:0] CC_NE     = 4'd6;
    localparam logic [3:0] CC_EQ     = 4'd7;
    localparam logic [3:0] CC_VC     = 4'd8;
    localparam logic [3:0] CC_VS     = 4'd9;
    localparam logic [3:0] CC_PL     = 4'd10;
    localparam logic [3:0] CC_MI     = 4'd11;
    localparam logic [3:0] CC_GE     = 4'd12;
    localparam logic [3:0] CC_LT     = 4'd13;
    localparam logic [3:0] CC_GT     = 4'd14;
    localparam logic [3:0] CC_LE     = 4'd15;

    // Decimal adjust corrections and the sign-extension fill
    localparam logic [7:0] DAA_FIX_LO = 8'h06;
    localparam logic [7:0] DAA_FIX_HI = 8'h60;
    localparam logic [7:0] SEX_ONES   = 8'hFF;

    typedef struct packed {
        logic [3:0]  action;
        logic [1:0]  target;
        logic [15:0] operand;
        logic [3:0]  condition;
    } item_t;

    typedef struct packed {
        logic [15:0] result_value;
        logic        write_memory;
        logic        carry_out;
        logic        zero_out;
        logic        negative_out;
        logic        overflow_out;
        logic        half_out;
        logic        branch_taken;
    } result_t;

    typedef struct packed {
        logic [7:0] acc_a;
        logic [7:0] acc_b;
        logic       carry;
        logic       zero;
        logic       negative;
        logic       overflow;
        logic       half;
    } alu_state_t;

endpackage

@@ src/accumulator_alu_with_condition_codes.sv @@
// Top level of the accumulator ALU: input register, execute stage, result register.
//
// An 8-bit accumulator ALU after the 6809: accumulators A and B with the C, Z, N, V and H
// flags. Each command word names one operation and returns one result word carrying the
// new value, the flags after the operation and the branch decision. The block takes one
// word per clock unless rsp_stall holds it, and returns words in order. A command word
// is held in the input register, then the execute logic works on it against the current
// accumulators and flags, writing them back and loading the result register at the same
// edge; so the next command already sees the updated state. The result word is offered
// once the single execute stage has loaded it into the result register; only rsp_stall
// slows the pace. The result register parts the two sides: a command is still taken
// while a finished result waits, and cmd_stall rises only once both the input register
// and the result register are full and rsp_stall is high. Reset clears A, B and all flags.
module accumulator_alu_with_condition_codes
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  accalu_pkg::item_t    cmd,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output accalu_pkg::result_t  rsp
);
    import accalu_pkg::*;

    item_t      cmd_reg;
    logic       cmd_valid_reg;
    logic       cmd_valid_next;
    result_t    rsp_reg;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    alu_state_t st_reg;
    alu_state_t st_next;
    result_t    exec_res;
    logic       out_free;
    logic       exec_fire;
    logic       cmd_take;

    // Result register frees when empty or being taken this cycle
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign exec_fire = cmd_valid_reg && out_free;
    assign cmd_stall = cmd_valid_reg && !out_free;
    assign cmd_take  = cmd_valid && !cmd_stall;

    accalu_exec u_exec
    (
        .op      (cmd_reg),
        .st      (st_reg),
        .st_next (st_next),
        .res     (exec_res)
    );

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        if (cmd_take)
            cmd_valid_next = 1'b1;
        else if (exec_fire)
            cmd_valid_next = 1'b0;

        rsp_valid_next = rsp_valid_reg;
        if (exec_fire)
            rsp_valid_next = 1'b1;
        else if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            st_reg        <= '0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (exec_fire)
                st_reg <= st_next;
        end
    end

    // Payload registers: load the command word on acceptance, the result on execute
    always_ff @(posedge clk)
    begin
        if (cmd_take)
            cmd_reg <= cmd;
        if (exec_fire)
            rsp_reg <= exec_res;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ src/accalu_exec.sv @@
// Single-pass execute logic: one operation on the accumulators and flags.
module accalu_exec
(
    input  accalu_pkg::item_t      op,
    input  accalu_pkg::alu_state_t st,
    output accalu_pkg::alu_state_t st_next,
    output accalu_pkg::result_t    res
);
    import accalu_pkg::*;

    logic [7:0]  m;
    logic        use_b;
    logic        is_mem;
    logic        cin;
    logic [7:0]  acc_t;
    logic [7:0]  shf_t;
    logic [7:0]  shf_r;
    logic [15:0] d16;
    logic [8:0]  add9;
    logic [8:0]  sub9;
    logic [16:0] add17;
    logic [16:0] sub17;
    logic [15:0] prod;
    logic [3:0]  lo;
    logic [3:0]  hi;
    logic        fix_lo;
    logic        fix_hi;
    logic [7:0]  daa_r;
    logic        lt;
    logic        taken;

    always_comb
    begin
        m      = op.operand[7:0];
        use_b  = (op.target == TGT_B);
        is_mem = op.target[1];
        cin    = op.action[0] ? st.carry : 1'b0;
        acc_t  = use_b ? st.acc_b : st.acc_a;
        shf_t  = is_mem ? m : acc_t;
        d16    = {st.acc_a, st.acc_b};
        add9   = {1'b0, acc_t} + {1'b0, m} + {8'd0, cin};
        sub9   = {1'b0, acc_t} - {1'b0, m} - {8'd0, cin};
        add17  = {1'b0, d16} + {1'b0, op.operand};
        sub17  = {1'b0, d16} - {1'b0, op.operand};
        prod   = {8'd0, st.acc_a} * {8'd0, st.acc_b};

        lo     = st.acc_a[3:0];
        hi     = st.acc_a[7:4];
        fix_lo = (lo > 4'd9) || st.half;
        fix_hi = (hi > 4'd9) || st.carry || ((hi > 4'd8) && (lo > 4'd9));
        daa_r  = st.acc_a + (fix_lo ? DAA_FIX_LO : 8'd0) + (fix_hi ? DAA_FIX_HI : 8'd0);

        case (op.action)
            ACT_ASL: shf_r = {shf_t[6:0], 1'b0};
            ACT_ROL: shf_r = {shf_t[6:0], st.carry};
            ACT_ASR: shf_r = {shf_t[7], shf_t[7:1]};
            ACT_LSR: shf_r = {1'b0, shf_t[7:1]};
            default: shf_r = {st.carry, shf_t[7:1]};
        endcase

        // Branch conditions on the flags as they stand
        lt = st.negative ^ st.overflow;
        case (op.condition)
            CC_ALWAYS: taken = 1'b1;
            CC_NEVER:  taken = 1'b0;
            CC_HI:     taken = !(st.carry | st.zero);
            CC_LS:     taken = st.carry | st.zero;
            CC_CC:     taken = !st.carry;
            CC_CS:     taken = st.carry;
            CC_NE:     taken = !st.zero;
            CC_EQ:     taken = st.zero;
            CC_VC:     taken = !st.overflow;
            CC_VS:     taken = st.overflow;
            CC_PL:     taken = !st.negative;
            CC_MI:     taken = st.negative;
            CC_GE:     taken = !lt;
            CC_LT:     taken = lt;
            CC_GT:     taken = !(lt | st.zero);
            default:   taken = lt | st.zero;
        endcase

        st_next = st;
        res     = '0;

        case (op.action)
            ACT_ADD, ACT_ADC:
            begin
                st_next.overflow = (acc_t[7] ^ add9[7]) & (m[7] ^ add9[7]);
                st_next.half     = acc_t[4] ^ m[4] ^ add9[4];
                st_next.carry    = add9[8];
                st_next.zero     = (add9[7:0] == 8'd0);
                st_next.negative = add9[7];
                if (use_b)
                    st_next.acc_b = add9[7:0];
                else
                    st_next.acc_a = add9[7:0];
                res.result_value = {8'd0, add9[7:0]};
            end
            ACT_SUB, ACT_SBC:
            begin
                st_next.overflow = (acc_t[7] ^ m[7]) & (acc_t[7] ^ sub9[7]);
                st_next.carry    = sub9[8];
                st_next.zero     = (sub9[7:0] == 8'd0);
                st_next.negative = sub9[7];
                if (use_b)
                    st_next.acc_b = sub9[7:0];
                else
                    st_next.acc_a = sub9[7:0];
                res.result_value = {8'd0, sub9[7:0]};
            end
            ACT_ADDD:
            begin
                st_next.overflow = (d16[15] ^ add17[15]) & (op.operand[15] ^ add17[15]);
                st_next.carry    = add17[16];
                st_next.zero     = (add17[15:0] == 16'd0);
                st_next.negative = add17[15];
                st_next.acc_a    = add17[15:8];
                st_next.acc_b    = add17[7:0];
                res.result_value = add17[15:0];
            end
            ACT_SUBD:
            begin
                st_next.overflow = (d16[15] ^ op.operand[15]) & (d16[15] ^ sub17[15]);
                st_next.carry    = sub17[16];
                st_next.zero     = (sub17[15:0] == 16'd0);
                st_next.negative = sub17[15];
                st_next.acc_a    = sub17[15:8];
                st_next.acc_b    = sub17[7:0];
                res.result_value = sub17[15:0];
            end
            ACT_MUL:
            begin
                st_next.zero     = (prod == 16'd0);
                st_next.carry    = prod[7];
                st_next.acc_a    = prod[15:8];
                st_next.acc_b    = prod[7:0];
                res.result_value = prod;
            end
            ACT_SEX:
            begin
                st_next.acc_a    = st.acc_b[7] ? SEX_ONES : 8'd0;
                st_next.zero     = (st.acc_b == 8'd0);
                st_next.negative = st.acc_b[7];
                res.result_value = {8'd0, st_next.acc_a};
            end
            ACT_ASL, ACT_ROL:
            begin
                st_next.carry    = shf_t[7];
                st_next.overflow = shf_t[7] ^ shf_t[6];
                st_next.zero     = (shf_r == 8'd0);
                st_next.negative = shf_r[7];
                res.write_memory = is_mem;
                if (!is_mem && use_b)
                    st_next.acc_b = shf_r;
                else if (!is_mem)
                    st_next.acc_a = shf_r;
                res.result_value = {8'd0, shf_r};
            end
            ACT_ASR, ACT_LSR, ACT_ROR:
            begin
                st_next.carry    = shf_t[0];
                st_next.zero     = (shf_r == 8'd0);
                st_next.negative = shf_r[7];
                res.write_memory = is_mem;
                if (!is_mem && use_b)
                    st_next.acc_b = shf_r;
                else if (!is_mem)
                    st_next.acc_a = shf_r;
                res.result_value = {8'd0, shf_r};
            end
            ACT_DAA:
            begin
                if (fix_hi)
                    st_next.carry = 1'b1;
                st_next.zero     = (daa_r == 8'd0);
                st_next.negative = daa_r[7];
                st_next.acc_a    = daa_r;
                res.result_value = {8'd0, daa_r};
            end
            ACT_BRA:
            begin
                res.branch_taken = taken;
            end
            default:
            begin
                res.branch_taken = 1'b0;
            end
        endcase

        res.carry_out    = st_next.carry;
        res.zero_out     = st_next.zero;
        res.negative_out = st_next.negative;
        res.overflow_out = st_next.overflow;
        res.half_out     = st_next.half;
    end

endmodule

@@ src/accalu_checker.sv @@
// Port-level checks for the accumulator ALU, bound to the top level.
module accalu_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_stall,
    input accalu_pkg::item_t   cmd,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input accalu_pkg::result_t rsp
);
    import accalu_pkg::*;

    // A stalled command word stays offered and keeps its value
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
        else $error("command word changed while stalled");

    // A stalled result word stays offered
    a_rsp_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its value
    a_rsp_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(rsp))
        else $error("result word changed while stalled");

    // Back-pressure on commands only when a result word is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> rsp_valid && rsp_stall)
        else $error("command stalled without a blocked result");

    // A memory write-back word never carries a taken branch
    a_wmem_branch: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.write_memory |-> !rsp.branch_taken)
        else $error("write-back and branch decision in one word");

endmodule

bind accumulator_alu_with_condition_codes accalu_checker u_accalu_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
